// File: rtl/assert_macros.svh
// Assertion macros shared by the modules of the escape-time pixel core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/jet_pkg.sv
// Types, constants and saturation helper shared by the escape-time pixel core.
package jet_pkg;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int COORD_BITS    = 32;
    localparam int PROD_BITS     = 64;
    localparam int COLOR_BITS    = 8;
    localparam int ESCAPE_RADIUS = 100;

    localparam logic [COLOR_BITS-1:0] COLOR_BASE        = 8'd16;
    localparam logic [COLOR_BITS-1:0] COLOR_LIMIT_RESET = 8'd255;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_C_REAL      = 3'd0,
        CFG_C_IMAG      = 3'd1,
        CFG_X_MIN       = 3'd2,
        CFG_X_STEP      = 3'd3,
        CFG_Y_MIN       = 3'd4,
        CFG_Y_STEP      = 3'd5,
        CFG_COLOR_LIMIT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] c_real;
        logic signed [COORD_BITS-1:0] c_imag;
        logic signed [COORD_BITS-1:0] x_min;
        logic signed [COORD_BITS-1:0] x_step;
        logic signed [COORD_BITS-1:0] y_min;
        logic signed [COORD_BITS-1:0] y_step;
        logic [COLOR_BITS-1:0]        color_limit;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_ADD,
        ST_MUL,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic res_base;
        logic res_color;
        logic init_mul;
        logic init_add;
        logic mul;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic small_limit;
        logic escaped;
        logic at_limit;
        logic out_free;
    } t_sts;

    function automatic logic signed [COORD_BITS-1:0] sat32(input logic signed [PROD_BITS-1:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[COORD_BITS-1:0];
        end
    endfunction

endpackage

// File: rtl/jet_cfg.sv
// Configuration register file of the escape-time pixel core.
module jet_cfg import jet_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_real      <= '0;
            r_cfg.c_imag      <= '0;
            r_cfg.x_min       <= '0;
            r_cfg.x_step      <= '0;
            r_cfg.y_min       <= '0;
            r_cfg.y_step      <= '0;
            r_cfg.color_limit <= COLOR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_C_REAL:      r_cfg.c_real      <= i_cfg_wdata;
                CFG_C_IMAG:      r_cfg.c_imag      <= i_cfg_wdata;
                CFG_X_MIN:       r_cfg.x_min       <= i_cfg_wdata;
                CFG_X_STEP:      r_cfg.x_step      <= i_cfg_wdata;
                CFG_Y_MIN:       r_cfg.y_min       <= i_cfg_wdata;
                CFG_Y_STEP:      r_cfg.y_step      <= i_cfg_wdata;
                CFG_COLOR_LIMIT: r_cfg.color_limit <= i_cfg_wdata[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/jet_ctrl.sv
// Sequencer that steps one pixel through set-up, iteration and result transfer.
`include "assert_macros.svh"
module jet_ctrl import jet_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.small_limit) begin
                        o_cmd.res_base = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        n_state = ST_INIT_MUL;
                    end
                end
            end
            ST_INIT_MUL: begin
                o_cmd.init_mul = 1'b1;
                n_state        = ST_INIT_ADD;
            end
            ST_INIT_ADD: begin
                o_cmd.init_add = 1'b1;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.escaped) begin
                    o_cmd.res_color = 1'b1;
                    n_state         = ST_DONE;
                end else if (i_sts.at_limit) begin
                    o_cmd.res_base = 1'b1;
                    n_state        = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_busy_after_transfer, (r_state == ST_IDLE) && i_in_valid, r_state != ST_IDLE)

endmodule

// File: rtl/jet_dp.sv
// Datapath: start point, shared multipliers, complex step, escape test and result register.
`include "assert_macros.svh"
module jet_dp import jet_pkg::*; #(
    parameter int FRAC_BITS  = 24,
    parameter int PIXEL_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    input  logic [PIXEL_BITS-1:0] i_pixel_col,
    input  logic [PIXEL_BITS-1:0] i_pixel_row,
    input  logic                  i_out_stall,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [COLOR_BITS-1:0] o_color_index,
    output logic [PIXEL_BITS-1:0] o_out_col,
    output logic [PIXEL_BITS-1:0] o_out_row
);

    localparam int PAD_BITS = COORD_BITS - PIXEL_BITS;
    localparam logic [PROD_BITS-1:0] RADIUS = PROD_BITS'(ESCAPE_RADIUS) << FRAC_BITS;

    logic [PIXEL_BITS-1:0]        r_col;
    logic [PIXEL_BITS-1:0]        r_row;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [PROD_BITS-1:0]  r_px;
    logic signed [PROD_BITS-1:0]  r_py;
    logic signed [PROD_BITS-1:0]  r_pxy;
    logic [COLOR_BITS-1:0]        r_color;
    logic                         r_first;
    logic [COLOR_BITS-1:0]        r_res_color;
    logic                         r_out_valid;
    logic [COLOR_BITS-1:0]        r_out_color;
    logic [PIXEL_BITS-1:0]        r_out_col;
    logic [PIXEL_BITS-1:0]        r_out_row;

    logic signed [COORD_BITS-1:0] w_a1;
    logic signed [COORD_BITS-1:0] w_b1;
    logic signed [COORD_BITS-1:0] w_a2;
    logic signed [COORD_BITS-1:0] w_b2;
    logic signed [PROD_BITS-1:0]  w_p1;
    logic signed [PROD_BITS-1:0]  w_p2;
    logic signed [PROD_BITS-1:0]  w_p3;
    logic signed [COORD_BITS-1:0] w_x0;
    logic signed [COORD_BITS-1:0] w_y0;
    logic signed [COORD_BITS-1:0] w_xx;
    logic signed [COORD_BITS-1:0] w_yy;
    logic signed [COORD_BITS-1:0] w_xy2;
    logic signed [COORD_BITS-1:0] w_xn;
    logic signed [COORD_BITS-1:0] w_yn;
    logic [PROD_BITS-1:0]         w_mag;
    logic                         w_escape;

    // During set-up the two squaring multipliers form the step products instead.
    always_comb begin
        w_a1 = i_cmd.init_mul ? i_cfg.x_step : r_x;
        w_b1 = i_cmd.init_mul ? $signed({{PAD_BITS{1'b0}}, r_col}) : r_x;
        w_a2 = i_cmd.init_mul ? i_cfg.y_step : r_y;
        w_b2 = i_cmd.init_mul ? $signed({{PAD_BITS{1'b0}}, r_row}) : r_y;
        w_p1 = w_a1 * w_b1;
        w_p2 = w_a2 * w_b2;
        w_p3 = r_x * r_y;
    end

    always_comb begin
        w_x0     = sat32(PROD_BITS'(i_cfg.x_min) + r_px);
        w_y0     = sat32(PROD_BITS'(i_cfg.y_min) + r_py);
        w_xx     = sat32(r_px >>> FRAC_BITS);
        w_yy     = sat32(r_py >>> FRAC_BITS);
        w_xy2    = sat32(r_pxy >>> (FRAC_BITS - 1));
        w_xn     = sat32(PROD_BITS'(w_xx) - PROD_BITS'(w_yy) + PROD_BITS'(i_cfg.c_real));
        w_yn     = sat32(PROD_BITS'(w_xy2) + PROD_BITS'(i_cfg.c_imag));
        w_mag    = $unsigned(r_px) + $unsigned(r_py);
        w_escape = (w_mag >> FRAC_BITS) > RADIUS;
    end

    assign o_sts.small_limit = i_cfg.color_limit <= COLOR_BASE;
    assign o_sts.escaped     = !r_first && w_escape;
    assign o_sts.at_limit    = !r_first && (r_color == i_cfg.color_limit);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
        if (i_cmd.init_mul || i_cmd.mul) begin
            r_px  <= w_p1;
            r_py  <= w_p2;
            r_pxy <= w_p3;
        end
        if (i_cmd.init_add) begin
            r_x     <= w_x0;
            r_y     <= w_y0;
            r_color <= COLOR_BASE;
            r_first <= 1'b1;
        end else if (i_cmd.step) begin
            r_x     <= w_xn;
            r_y     <= w_yn;
            r_color <= r_color + 8'd1;
            r_first <= 1'b0;
        end
        if (i_cmd.res_base) begin
            r_res_color <= COLOR_BASE;
        end else if (i_cmd.res_color) begin
            r_res_color <= r_color;
        end
        if (i_cmd.out_load) begin
            r_out_color <= r_res_color;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_color_index = r_out_color;
    assign o_out_col     = r_out_col;
    assign o_out_row     = r_out_row;

    `ASSERT_IMPL(a_out_load_free, i_cmd.out_load, !r_out_valid || !i_out_stall)
    `ASSERT_IMPL(a_step_below_limit, i_cmd.step, r_color < i_cfg.color_limit)

endmodule

// File: rtl/julia_escape_time_pixel_core.sv
// Julia set escape-time pixel core: top level joining config, sequencer and datapath.
// Each pixel runs 1 to 239 iteration steps, ending on escape or at the color limit.
// A color limit of 16 or less gives the base color with no iteration. Each iteration
// passes first through the three 32x32 multipliers, two of them shared with set-up,
// then through the shift, saturate and add step with the escape compare.
// One pixel is in flight at a time; the next pixel transfers once the previous result
// has moved to the output register, even while that result waits there.
module julia_escape_time_pixel_core import jet_pkg::*; #(
    parameter int FRAC_BITS  = 24,
    parameter int PIXEL_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [PIXEL_BITS-1:0]    i_pixel_col,
    input  logic [PIXEL_BITS-1:0]    i_pixel_row,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [COLOR_BITS-1:0]    o_color_index,
    output logic [PIXEL_BITS-1:0]    o_out_col,
    output logic [PIXEL_BITS-1:0]    o_out_row
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    jet_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    jet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    jet_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_out_stall   (i_out_stall),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .o_color_index (o_color_index),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row)
    );

endmodule
